// ===== rtl/core/lkv_pkg.sv =====
// ---------------------------------------------------------------------------
// lkv_pkg: shared definitions for the LRU key/value cache
// Sizes, command codes and the controller/datapath interface structs.
// ---------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

    // Table geometry
    localparam int LKV_ENTRIES = 16;
    localparam int LKV_SLOT_W  = $clog2(LKV_ENTRIES);
    localparam int LKV_AGE_W   = $clog2(LKV_ENTRIES);
    localparam int LKV_CNT_W   = $clog2(LKV_ENTRIES + 1);

    // Field widths
    localparam int LKV_KEY_W = 32;
    localparam int LKV_VAL_W = 32;
    localparam int LKV_CAP_W = 5;

    // Configuration
    localparam int                 LKV_ADDR_W    = 3;
    localparam logic [LKV_CAP_W-1:0] LKV_CAP_RESET = 5'd16;
    localparam logic               REG_CAPACITY  = 1'b0;

    // Item commands
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming item
        logic exec;      // look up and update the table
        logic load_out;  // move the result into the output register
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic                 is_put;
        logic [LKV_CNT_W-1:0] count;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/core/lru_key_value_cache_unit.sv =====
// ---------------------------------------------------------------------------
// lru_key_value_cache_unit: fully associative key/value cache, LRU replace
//
// Input channel (i_in_valid / o_in_stall) carries one item: i_command
// (get or put), i_key and i_value. A get gives one result on the output
// channel (o_out_valid / i_out_stall): o_hit and o_read_value, zero on a
// miss. A put gives no result; it updates a present key or inserts a new
// one, evicting the least recent entry once the entry count reaches the
// capacity register (APB, byte address 0, reset 16).
// Sequence: a put passes the accept and table update states before the next
// accept; a get also passes the response state, where the registered read of
// the value RAM is loaded into the result. The result sits in an output
// register, so the next item is accepted while it waits; a get whose result
// cannot load because the previous one is still stalled holds in the
// response state.
// Reset (synchronous, active low) empties the table at once and sets the
// capacity to 16; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // Item input
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic                                 i_command,
    input  wire logic signed [lkv_pkg::LKV_KEY_W-1:0] i_key,
    input  wire logic signed [lkv_pkg::LKV_VAL_W-1:0] i_value,
    // Result output
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic                                      o_hit,
    output logic signed      [lkv_pkg::LKV_VAL_W-1:0] o_read_value,
    // Configuration
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic        [lkv_pkg::LKV_ADDR_W-1:0] paddr,
    input  wire logic        [31:0]                   pwdata,
    output logic             [31:0]                   prdata,
    output logic                                      pready
);

    import lkv_pkg::*;

    logic [LKV_CAP_W-1:0] r_capacity;
    logic                 cfg_wr;
    t_ctrl_cmd            cmd;
    t_dp_status           status;
    logic [LKV_VAL_W-1:0] read_value;

    // Capacity register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= LKV_CAP_RESET;
        end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
            r_capacity <= pwdata[LKV_CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(r_capacity) : '0;

    lkv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lkv_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_command    (i_command),
        .i_key        (i_key),
        .i_value      (i_value),
        .i_capacity   (r_capacity),
        .o_hit        (o_hit),
        .o_read_value (read_value)
    );

    assign o_read_value = read_value;

`ifndef NO_ASSERTIONS
    // An accepted item blocks the input for the next cycle
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // The entry count never exceeds the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.count <= LKV_CNT_W'(LKV_ENTRIES))
        else $error("entry count out of range");

    // A new result appears only after a load command
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.load_out))
        else $error("output valid without load");

    // A miss reports a zero value
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_read_value == '0))
        else $error("miss with nonzero value");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/lkv_ram.sv =====
// ---------------------------------------------------------------------------
// lkv_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lkv_datapath.sv =====
// ---------------------------------------------------------------------------
// lkv_datapath: tag store, recency ranks and value memory
// Parallel key match, victim and free-slot selection, age update, output
// register.
// ---------------------------------------------------------------------------
`default_nettype none

module lkv_datapath (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire lkv_pkg::t_ctrl_cmd               i_cmd,
    output lkv_pkg::t_dp_status                   o_status,
    input  wire logic                             i_command,
    input  wire logic [lkv_pkg::LKV_KEY_W-1:0]    i_key,
    input  wire logic [lkv_pkg::LKV_VAL_W-1:0]    i_value,
    input  wire logic [lkv_pkg::LKV_CAP_W-1:0]    i_capacity,
    output logic                                  o_hit,
    output logic      [lkv_pkg::LKV_VAL_W-1:0]    o_read_value
);

    import lkv_pkg::*;

    // Latched item
    logic                 r_cmd;
    logic [LKV_KEY_W-1:0] r_key_in;
    logic [LKV_VAL_W-1:0] r_val_in;

    // Table state
    logic [LKV_ENTRIES-1:0] r_valid, n_valid;
    logic [LKV_KEY_W-1:0]   r_key [LKV_ENTRIES];
    logic [LKV_AGE_W-1:0]   r_age [LKV_ENTRIES];
    logic [LKV_AGE_W-1:0]   n_age [LKV_ENTRIES];
    logic [LKV_CNT_W-1:0]   r_count, n_count;
    logic                   r_hit;

    // Lookup results
    logic [LKV_ENTRIES-1:0] match;
    logic                   hit;
    logic [LKV_SLOT_W-1:0]  hit_idx, victim_idx, free_idx, target;
    logic [LKV_CNT_W-1:0]   eff_cap, cnt_m1, age_lim;
    logic [LKV_AGE_W-1:0]   oldest_age;
    logic                   evict, is_put, do_touch, do_insert;
    logic [LKV_VAL_W-1:0]   ram_rdata;

    // Clamp capacity into 1..LKV_ENTRIES
    always_comb begin
        if (i_capacity == '0) begin
            eff_cap = LKV_CNT_W'(1);
        end else if (LKV_CNT_W'(i_capacity) > LKV_CNT_W'(LKV_ENTRIES)
                     || i_capacity > LKV_CAP_W'(LKV_ENTRIES)) begin
            eff_cap = LKV_CNT_W'(LKV_ENTRIES);
        end else begin
            eff_cap = LKV_CNT_W'(i_capacity);
        end
    end

    // Ranks of valid slots are always 0..count-1, so the oldest has rank count-1
    assign cnt_m1     = r_count - LKV_CNT_W'(1);
    assign oldest_age = cnt_m1[LKV_AGE_W-1:0];

    // Parallel key compare and slot encoders
    always_comb begin
        hit_idx    = '0;
        victim_idx = '0;
        free_idx   = '0;
        for (int i = 0; i < LKV_ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_key[i] == r_key_in);
            if (match[i]) begin
                hit_idx = hit_idx | LKV_SLOT_W'(i);
            end
            if (r_valid[i] && (r_age[i] == oldest_age)) begin
                victim_idx = victim_idx | LKV_SLOT_W'(i);
            end
        end
        for (int i = LKV_ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = LKV_SLOT_W'(i);
            end
        end
    end

    assign hit    = |match;
    assign is_put = (r_cmd == CMD_PUT);
    assign evict  = (r_count >= eff_cap) && (r_count != '0);
    assign target = hit ? hit_idx : (evict ? victim_idx : free_idx);

    assign do_touch  = i_cmd.exec && (is_put || hit);
    assign do_insert = is_put && !hit && !evict;

    // Entries younger than the limit age by one; a new key ages everyone
    assign age_lim = do_insert ? LKV_CNT_W'(LKV_ENTRIES) : LKV_CNT_W'(r_age[target]);

    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        for (int i = 0; i < LKV_ENTRIES; i++) begin
            n_age[i] = r_age[i];
        end
        if (do_touch) begin
            for (int i = 0; i < LKV_ENTRIES; i++) begin
                if (r_valid[i] && (LKV_CNT_W'(r_age[i]) < age_lim)) begin
                    n_age[i] = r_age[i] + LKV_AGE_W'(1);
                end
            end
            n_age[target] = '0;
            if (is_put) begin
                n_valid[target] = 1'b1;
            end
            if (do_insert) begin
                n_count = r_count + LKV_CNT_W'(1);
            end
        end
    end

    // Table control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int i = 0; i < LKV_ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            for (int i = 0; i < LKV_ENTRIES; i++) begin
                r_age[i] <= n_age[i];
            end
        end
    end

    // Key store and item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd    <= i_command;
            r_key_in <= i_key;
            r_val_in <= i_value;
        end
        if (do_touch && is_put) begin
            r_key[target] <= r_key_in;
        end
        if (i_cmd.exec) begin
            r_hit <= hit;
        end
    end

    // Value memory: write on put, read the hit slot on get
    lkv_ram #(
        .WIDTH (LKV_VAL_W),
        .DEPTH (LKV_ENTRIES)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && is_put),
        .i_waddr (target),
        .i_wdata (r_val_in),
        .i_re    (i_cmd.exec && !is_put),
        .i_raddr (target),
        .o_rdata (ram_rdata)
    );

    // Output register: zero value on a miss
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_hit        <= r_hit;
            o_read_value <= r_hit ? ram_rdata : '0;
        end
    end

    assign o_status.is_put = is_put;
    assign o_status.count  = r_count;

endmodule

`default_nettype wire

// ===== rtl/core/lkv_ctrl.sv =====
// ---------------------------------------------------------------------------
// lkv_ctrl: item sequencer for the LRU key/value cache
// Accept, execute and respond states plus the output valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module lkv_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    input  wire lkv_pkg::t_dp_status  i_status,
    output lkv_pkg::t_ctrl_cmd        o_cmd
);

    import lkv_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd.capture  = 1'b0;
        o_cmd.exec     = 1'b0;
        o_cmd.load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.is_put ? ST_IDLE : ST_RESP;
            end
            ST_RESP: begin
                // Hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output valid: drop when taken, set on load
    assign n_out_valid = o_cmd.load_out || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire
